@@ rtl/direction_cosines_to_ra_dec_assert.svh @@
// Assertion macros for the sky-position converter.
`ifndef DIRECTION_COSINES_TO_RA_DEC_ASSERT_SVH
`define DIRECTION_COSINES_TO_RA_DEC_ASSERT_SVH
`ifndef SYNTH
// Checks that a condition implies a consequence in the next cycle.
`define DCR_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");
// Checks that a condition implies a consequence in the same cycle.
`define DCR_ASSERT_NOW(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");
`else
`define DCR_ASSERT_NEXT(label, clk, rst, cond, cons)
`define DCR_ASSERT_NOW(label, clk, rst, cond, cons)
`endif
`endif

@@ rtl/dcr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package dcr_pkg;
  // Fixed-point layout of the internal datapath.
  localparam int FRAC = 58;
  localparam int ITERS = 60;
  localparam logic [63:0] TURN_PER_RAD = 64'h28BE60DB9391054A;

  // Configuration register indexes.
  localparam logic CFG_CENTRE_RA = 1'b0;
  localparam logic CFG_CENTRE_DEC = 1'b1;

  // Arctangent of 2^-i, units of 2^-64 turn.
  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int k;
    acc = 64'd0;
    if (i == 0) begin
      acc = 64'h2000000000000000;
    end else begin
      for (k = 0; k < 32; k++) begin
        if (i * (2 * k + 1) < 64) begin
          term = (TURN_PER_RAD >> (i * (2 * k + 1))) / 64'(2 * k + 1);
          if (k[0]) acc = acc - term;
          else acc = acc + term;
        end
      end
    end
    return acc;
  endfunction
endpackage
`default_nettype wire

@@ rtl/dcr_vec_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One CORDIC micro-rotation cell; mode picks rotation or vectoring.
module dcr_vec_cell #(
  parameter int STEP = 0,
  parameter int SW = 1
) (
  input  wire logic clk,
  input  wire logic adv,
  input  wire logic rotate,
  input  wire logic signed [63:0] x_in,
  input  wire logic signed [63:0] y_in,
  input  wire logic [63:0] a_in,
  input  wire logic [SW-1:0] side_in,
  output logic signed [63:0] x_out,
  output logic signed [63:0] y_out,
  output logic [63:0] a_out,
  output logic [SW-1:0] side_out
);
  localparam logic [63:0] ATAN = dcr_pkg::atan_entry(STEP);
  logic plus;
  logic signed [63:0] xs;
  logic signed [63:0] ys;

  // Direction: rotation follows angle sign, vectoring follows y sign.
  always_comb begin
    plus = rotate ? !a_in[63] : !y_in[63];
    xs = x_in >>> STEP;
    ys = y_in >>> STEP;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_out <= side_in;
      if (rotate) begin
        x_out <= plus ? x_in - ys : x_in + ys;
        y_out <= plus ? y_in + xs : y_in - xs;
        a_out <= plus ? a_in - ATAN : a_in + ATAN;
      end else begin
        x_out <= plus ? x_in + ys : x_in - ys;
        y_out <= plus ? y_in - xs : y_in + xs;
        a_out <= plus ? a_in + ATAN : a_in - ATAN;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/dcr_chain.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Row of CORDIC cells, one per iteration, with a side payload.
module dcr_chain #(
  parameter int SW = 1
) (
  input  wire logic clk,
  input  wire logic adv,
  input  wire logic rotate,
  input  wire logic signed [63:0] x_in,
  input  wire logic signed [63:0] y_in,
  input  wire logic [63:0] a_in,
  input  wire logic [SW-1:0] side_in,
  output logic signed [63:0] x_out,
  output logic signed [63:0] y_out,
  output logic [63:0] a_out,
  output logic [SW-1:0] side_out
);
  logic signed [63:0] xv [dcr_pkg::ITERS+1];
  logic signed [63:0] yv [dcr_pkg::ITERS+1];
  logic [63:0] av [dcr_pkg::ITERS+1];
  logic [SW-1:0] sv [dcr_pkg::ITERS+1];

  assign xv[0] = x_in;
  assign yv[0] = y_in;
  assign av[0] = a_in;
  assign sv[0] = side_in;

  for (genvar g = 0; g < dcr_pkg::ITERS; g++) begin : g_cell
    dcr_vec_cell #(.STEP(g), .SW(SW)) u_cell (
      .clk(clk), .adv(adv), .rotate(rotate),
      .x_in(xv[g]), .y_in(yv[g]), .a_in(av[g]), .side_in(sv[g]),
      .x_out(xv[g+1]), .y_out(yv[g+1]), .a_out(av[g+1]), .side_out(sv[g+1])
    );
  end

  assign x_out = xv[dcr_pkg::ITERS];
  assign y_out = yv[dcr_pkg::ITERS];
  assign a_out = av[dcr_pkg::ITERS];
  assign side_out = sv[dcr_pkg::ITERS];
endmodule
`default_nettype wire

@@ rtl/dcr_sqrt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One restoring square-root step; one root bit per cycle while adv is high.
module dcr_sqrt_cell #(
  parameter int BITPOS = 0,
  parameter int SW = 1
) (
  input  wire logic clk,
  input  wire logic adv,
  input  wire logic [127:0] rad_in,
  input  wire logic [63:0] root_in,
  input  wire logic [SW-1:0] side_in,
  output logic [127:0] rad_out,
  output logic [63:0] root_out,
  output logic [SW-1:0] side_out
);
  logic [63:0] trial;
  logic [127:0] sq;

  // The trial square fits one wide compare; root bits below BITPOS are zero.
  always_comb begin
    trial = root_in | (64'd1 << BITPOS);
    sq = {64'd0, root_in} << (BITPOS + 1);
    sq = sq + (128'd1 << (2 * BITPOS));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_out <= side_in;
      if (sq <= rad_in) begin
        root_out <= trial;
        rad_out <= rad_in - sq;
      end else begin
        root_out <= root_in;
        rad_out <= rad_in;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/direction_cosines_to_ra_dec.sv @@
// Channel   Dir  Payload
// s_axis    in   tdata {dir_m, dir_l}, tuser last_in
// m_axis    out  tdata {declination, right_asc}, tuser {last_out, off_sphere}
// cfg       in   index 0 centre_ra, 1 centre_dec
// One item per cycle unless stalled, through 60 root cells, four product
// stages, three CORDIC cell rows of 60 in series and three single registers.
// A one-item skid register behind the output register takes the item that
// arrives while the output waits; the pipeline advances whenever it is empty.
// Reset is synchronous and clears valid bits and the centre registers.
`timescale 1ns / 1ps
`default_nettype none
`include "direction_cosines_to_ra_dec_assert.svh"
module direction_cosines_to_ra_dec #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input  wire logic [2*COORD_BITS-1:0] s_axis_tdata,  // dir_l, dir_m
  input  wire logic s_axis_tuser,                     // last_in
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [2*ANGLE_BITS-1:0] m_axis_tdata,      // right_asc, declination
  output logic [1:0] m_axis_tuser,                    // off_sphere, last_out
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic cfg_index,
  input  wire logic [ANGLE_BITS-1:0] cfg_data
);
  localparam int FB = COORD_BITS - 2;
  localparam int SH = 2 * dcr_pkg::FRAC - 2 * FB;
  localparam int DEPTH = 60 + 4 + 3 * dcr_pkg::ITERS + 2;
  localparam logic [63:0] ONE_Q = 64'd1 << dcr_pkg::FRAC;

  logic [ANGLE_BITS-1:0] centre_ra;
  logic [ANGLE_BITS-1:0] centre_dec;
  logic adv;
  logic skid_valid;
  logic [DEPTH-1:0] vld;

  assign cfg_ready = 1'b1;
  assign adv = !skid_valid;
  assign s_axis_tready = adv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      centre_ra <= '0;
      centre_dec <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == dcr_pkg::CFG_CENTRE_RA) centre_ra <= cfg_data;
      else centre_dec <= cfg_data;
    end
  end

  // Valid shift line for the whole pipeline.
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[DEPTH-2:0], s_axis_tvalid};
  end

  // Stage 0: squares and radicand.
  logic signed [COORD_BITS-1:0] l_in, m_in;
  logic [COORD_BITS-1:0] ul, um;
  logic [2*COORD_BITS:0] ss;
  logic [127:0] rad0;
  logic off0;
  always_comb begin
    l_in = s_axis_tdata[COORD_BITS-1:0];
    m_in = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    ul = l_in[COORD_BITS-1] ? COORD_BITS'(-l_in) : COORD_BITS'(l_in);
    um = m_in[COORD_BITS-1] ? COORD_BITS'(-m_in) : COORD_BITS'(m_in);
    ss = (2*COORD_BITS+1)'(ul * ul) + (2*COORD_BITS+1)'(um * um);
    off0 = ss > ((2*COORD_BITS+1)'(1) << (2 * FB));
    rad0 = off0 ? 128'd0 : (128'((2*COORD_BITS+1)'(1) << (2 * FB)) - 128'(ss)) << SH;
  end

  // Side payload: l, m, off, last.
  localparam int SW1 = 2 * COORD_BITS + 2;
  logic [127:0] radv [61];
  logic [63:0] rootv [61];
  logic [SW1-1:0] sidev [61];
  assign radv[0] = rad0;
  assign rootv[0] = '0;
  assign sidev[0] = {s_axis_tuser, off0, m_in, l_in};
  for (genvar g = 0; g < 60; g++) begin : g_sqrt
    dcr_sqrt_cell #(.BITPOS(59 - g), .SW(SW1)) u_sq (
      .clk(clk), .adv(adv), .rad_in(radv[g]), .root_in(rootv[g]),
      .side_in(sidev[g]), .rad_out(radv[g+1]), .root_out(rootv[g+1]),
      .side_out(sidev[g+1])
    );
  end

  // Rotation chain for K*cos/K*sin of centre dec, parallel to the root; the
  // user, not the block, keeps the centre constant while items are in flight.
  logic [63:0] dec_a, dec_r;
  logic flip;
  logic signed [63:0] kc_r, ks_r;
  logic [63:0] unused_a;
  logic [0:0] unused_s;
  always_comb begin
    dec_a = {centre_dec, {(64-ANGLE_BITS){1'b0}}};
    flip = dec_a[63] ^ dec_a[62];
    dec_r = flip ? dec_a - (64'd1 << 63) : dec_a;
  end
  dcr_chain #(.SW(1)) u_rot (
    .clk(clk), .adv(adv), .rotate(1'b1), .x_in(ONE_Q), .y_in('0),
    .a_in(dec_r), .side_in(flip), .x_out(kc_r), .y_out(ks_r),
    .a_out(unused_a), .side_out(unused_s)
  );
  logic signed [63:0] kc, ks;
  assign kc = unused_s[0] ? -kc_r : kc_r;
  assign ks = unused_s[0] ? -ks_r : ks_r;

  // 32x32 partial product.
  function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
    return {32'd0, a} * {32'd0, b};
  endfunction

  // n, and l and m scaled to Q.58; n and m feed the products, l rides along.
  logic signed [63:0] n_q, lq, mq;
  logic signed [63:0] zk, xk, lq_r, lmag;
  logic [1:0] flg1;
  always_comb begin
    n_q = rootv[60];
    lq = 64'(signed'(sidev[60][COORD_BITS-1:0])) <<< (dcr_pkg::FRAC - FB);
    mq = 64'(signed'(sidev[60][2*COORD_BITS-1:COORD_BITS])) <<< (dcr_pkg::FRAC - FB);
  end

  // Product stage 1: magnitudes and signs. Products 0 to 3 are n*ks, m*kc,
  // n*kc and m*ks.
  logic [63:0] mag_n, mag_m, mag_c, mag_s;
  logic neg_m, neg_c, neg_s;
  logic [65:0] pside1, pside2, pside3;
  always_ff @(posedge clk) begin
    if (adv) begin
      mag_n <= n_q;
      mag_m <= mq[63] ? -mq : mq;
      mag_c <= kc[63] ? -kc : kc;
      mag_s <= ks[63] ? -ks : ks;
      neg_m <= mq[63];
      neg_c <= kc[63];
      neg_s <= ks[63];
      pside1 <= {sidev[60][SW1-1:SW1-2], lq};
    end
  end

  logic [63:0] opa [4];
  logic [63:0] opb [4];
  logic [3:0] neg_p;
  always_comb begin
    opa[0] = mag_n;
    opb[0] = mag_s;
    neg_p[0] = neg_s;
    opa[1] = mag_m;
    opb[1] = mag_c;
    neg_p[1] = neg_m ^ neg_c;
    opa[2] = mag_n;
    opb[2] = mag_c;
    neg_p[2] = neg_c;
    opa[3] = mag_m;
    opb[3] = mag_s;
    neg_p[3] = neg_m ^ neg_s;
  end

  // Product stage 2: four 32x32 partial products per product.
  logic [63:0] pp [4][4];
  logic [3:0] neg_pp;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int q = 0; q < 4; q++) begin
        pp[q][0] <= mul32(opa[q][31:0], opb[q][31:0]);
        pp[q][1] <= mul32(opa[q][31:0], opb[q][63:32]);
        pp[q][2] <= mul32(opa[q][63:32], opb[q][31:0]);
        pp[q][3] <= mul32(opa[q][63:32], opb[q][63:32]);
      end
      neg_pp <= neg_p;
      pside2 <= pside1;
    end
  end

  // Product stage 3: sum, round to nearest with ties away from zero.
  logic [127:0] psum [4];
  logic [63:0] prod [4];
  logic [3:0] neg_prod;
  always_comb begin
    for (int q = 0; q < 4; q++) begin
      psum[q] = {64'd0, pp[q][0]} + {32'd0, pp[q][1], 32'd0}
                + {32'd0, pp[q][2], 32'd0} + {pp[q][3], 64'd0}
                + (128'd1 << (dcr_pkg::FRAC - 1));
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int q = 0; q < 4; q++) begin
        prod[q] <= psum[q][dcr_pkg::FRAC +: 64];
      end
      neg_prod <= neg_pp;
      pside3 <= pside2;
    end
  end

  // Product stage 4: signed products combine into z and x.
  logic signed [63:0] qv [4];
  always_comb begin
    for (int q = 0; q < 4; q++) begin
      qv[q] = neg_prod[q] ? -prod[q] : prod[q];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      zk <= qv[0] + qv[1];
      xk <= qv[2] - qv[3];
      lq_r <= pside3[63:0];
      flg1 <= pside3[65:64];
    end
  end

  // K-scale of l and z in one vectoring row each, run side by side.
  localparam int SW2 = 64 + 2 + 1;
  logic signed [63:0] lk_m, zk_m, unused_y1, unused_y2;
  logic [63:0] unused_a1, unused_a2;
  logic [SW2-1:0] side2;
  logic [0:0] zsign;
  assign lmag = lq_r[63] ? -lq_r : lq_r;
  dcr_chain #(.SW(SW2)) u_kl (
    .clk(clk), .adv(adv), .rotate(1'b0), .x_in(lmag), .y_in('0), .a_in('0),
    .side_in({lq_r[63], flg1, xk}), .x_out(lk_m), .y_out(unused_y1),
    .a_out(unused_a1), .side_out(side2)
  );
  dcr_chain #(.SW(1)) u_kz (
    .clk(clk), .adv(adv), .rotate(1'b0), .x_in(zk[63] ? -zk : zk), .y_in('0),
    .a_in('0), .side_in(zk[63]), .x_out(zk_m), .y_out(unused_y2),
    .a_out(unused_a2), .side_out(zsign)
  );

  // Prepare first atan2: vector (x, l*K), with half-turn pre-rotation.
  logic signed [63:0] lk, zkk, x2;
  logic signed [63:0] vx, vy, vz;
  logic [63:0] va;
  logic [1:0] f3;
  logic vzero;
  always_comb begin
    lk = side2[SW2-1] ? -lk_m : lk_m;
    zkk = zsign[0] ? -zk_m : zk_m;
    x2 = side2[63:0];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      vzero <= (x2 == 0) && (lk == 0);
      vx <= x2[63] ? -x2 : x2;
      vy <= x2[63] ? -lk : lk;
      va <= x2[63] ? (64'd1 << 63) : 64'd0;
      vz <= zkk;
      f3 <= side2[65:64];
    end
  end

  logic signed [63:0] hk, unused_y3;
  logic [63:0] a1_raw;
  logic [SW2-1:0] side4;
  dcr_chain #(.SW(SW2)) u_v1 (
    .clk(clk), .adv(adv), .rotate(1'b0), .x_in(vx), .y_in(vy), .a_in(va),
    .side_in({vzero, f3, vz}), .x_out(hk), .y_out(unused_y3),
    .a_out(a1_raw), .side_out(side4)
  );

  // Second atan2 on (h*K, z*K); keep the first angle alongside.
  logic signed [63:0] hk0, wx, wy;
  logic [63:0] a1, wa;
  logic [1:0] f5;
  logic wzero;
  always_comb begin
    hk0 = side4[SW2-1] ? 64'd0 : hk;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a1 <= side4[SW2-1] ? 64'd0 : a1_raw;
      wzero <= (hk0 == 0) && (side4[63:0] == 0);
      wx <= hk0[63] ? -hk0 : hk0;
      wy <= hk0[63] ? -side4[63:0] : side4[63:0];
      wa <= hk0[63] ? (64'd1 << 63) : 64'd0;
      f5 <= side4[65:64];
    end
  end

  localparam int SW3 = 64 + 2 + 1;
  logic signed [63:0] unused_x6, unused_y6;
  logic [63:0] a2_raw;
  logic [SW3-1:0] side6;
  dcr_chain #(.SW(SW3)) u_v2 (
    .clk(clk), .adv(adv), .rotate(1'b0), .x_in(wx), .y_in(wy), .a_in(wa),
    .side_in({wzero, f5, a1}), .x_out(unused_x6), .y_out(unused_y6),
    .a_out(a2_raw), .side_out(side6)
  );

  // Round both angles to ANGLE_BITS.
  logic [63:0] ra_full, dec_full, a2;
  logic [2*ANGLE_BITS-1:0] out_data, skid_data;
  logic [1:0] out_user, skid_user;
  always_comb begin
    a2 = side6[SW3-1] ? 64'd0 : a2_raw;
    ra_full = {centre_ra, {(64-ANGLE_BITS){1'b0}}} + side6[63:0]
              + (64'd1 << (63 - ANGLE_BITS));
    dec_full = a2 + (64'd1 << (63 - ANGLE_BITS));
    out_data = {dec_full[63 -: ANGLE_BITS], ra_full[63 -: ANGLE_BITS]};
    out_user = {side6[65], side6[64]};
  end

  // Output register with a one-item skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= skid_valid || vld[DEPTH-1];
      skid_valid <= 1'b0;
    end else if (vld[DEPTH-1] && adv) begin
      skid_valid <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tdata <= skid_valid ? skid_data : out_data;
      m_axis_tuser <= skid_valid ? skid_user : out_user;
    end
    if (m_axis_tvalid && !m_axis_tready && adv) begin
      skid_data <= out_data;
      skid_user <= out_user;
    end
  end

  // Assertions.
  `DCR_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `DCR_ASSERT_NOW(a_ready, clk, rst, !m_axis_tvalid, s_axis_tready)
  `DCR_ASSERT_NEXT(a_stall, clk, rst, !adv, $stable(vld))
endmodule
`default_nettype wire
